>>> rtl/core/dhcp_lta_pkg.sv
// ----------------------------------------------------------------------------
// dhcp_lta_pkg
// Types, codes and helpers shared by the DHCP lease pool engine.
// ----------------------------------------------------------------------------
package dhcp_lta_pkg;

  localparam int unsigned POOL_DEPTH = 256;
  localparam int unsigned ID_W       = $clog2(POOL_DEPTH);
  localparam int unsigned LIFE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [LIFE_W-1:0] LIFE_FREE = 8'h00;
  localparam logic [LIFE_W-1:0] LIFE_INF  = 8'hff;
  localparam logic [LIFE_W-1:0] LIFE_MAX  = 8'hfe;
  localparam logic [LIFE_W-1:0] LIFE_MIN  = 8'h02;

  typedef enum logic [1:0] {
    CMD_DISCOVER = 2'd0,
    CMD_REQUEST  = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MSG_OFFER     = 2'd0,
    MSG_ACK       = 2'd1,
    MSG_NACK      = 2'd2,
    MSG_EXHAUSTED = 2'd3
  } msg_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE   = 3'd0,
    CFG_HOST_BITS   = 3'd1,
    CFG_GRANT_TIME  = 3'd2,
    CFG_RESV_EN     = 3'd3,
    CFG_RESV_ID     = 3'd4,
    CFG_OFFER_OPT   = 3'd5,
    CFG_UNUSED6     = 3'd6,
    CFG_UNUSED7     = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISC,
    ST_REQ,
    ST_TICK,
    ST_TICK_END
  } state_e;

  // Highest host ID of the search span: min(2^hb, depth) - 1, hb clamped to 1..8.
  function automatic logic [ID_W-1:0] span_max(input logic [3:0] host_bits);
    logic [3:0] hb;
    logic [8:0] span;
    hb = host_bits;
    if (hb < 4'd1) hb = 4'd1;
    if (hb > 4'd8) hb = 4'd8;
    span = 9'd1 << hb;
    if (32'(span) > POOL_DEPTH) begin
      span_max = ID_W'(POOL_DEPTH - 1);
    end else begin
      span_max = ID_W'(span - 9'd1);
    end
  endfunction

  // Lifetime after one timer tick.
  function automatic logic [LIFE_W-1:0] tick_life(input logic [LIFE_W-1:0] v);
    if (v <= 8'd1) begin
      tick_life = LIFE_FREE;
    end else if (v == LIFE_INF) begin
      tick_life = LIFE_INF;
    end else begin
      tick_life = v - 8'd1;
    end
  endfunction

endpackage

>>> rtl/core/dhcp_lta_ram.sv
// ----------------------------------------------------------------------------
// dhcp_lta_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dhcp_lta_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> rtl/core/dhcp_lease_table_allocator_top.sv
// ----------------------------------------------------------------------------
// dhcp_lease_table_allocator_top
// DHCP lease pool engine: lifetime table in RAM, discover/request/tick.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-----------------------------------
//  in      | in  | in_valid_i/in_ready_o  | cmd, client_hw, requested/sender
//  out     | out | out_valid_o/out_ready_i| msg_kind, echo, granted, option, uc
//  cfg     | in  | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// Request: table read, then update. Discover: up to max_id probes, one table
// probe per cycle through the RAM read port while the output register is free.
// Tick: pipelined read-modify-write sweep.
// After reset a clearing pass writes zero to every entry with in_ready_o low.
// A finished result stalls in its final state while the output register is
// still occupied.
// ----------------------------------------------------------------------------
module dhcp_lease_table_allocator_top
  import dhcp_lta_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           cmd_i,
  input  logic [47:0]          client_hw_i,
  input  logic [31:0]          requested_addr_i,
  input  logic [31:0]          sender_addr_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           msg_kind_o,
  output logic [47:0]          client_echo_o,
  output logic [31:0]          granted_addr_o,
  output logic [31:0]          option_addr_o,
  output logic                 unicast_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  localparam logic [ID_W-1:0] LastId = ID_W'(POOL_DEPTH - 1);

  // configuration
  logic [31:0] pool_base_q, offer_opt_q;
  logic [3:0]  host_bits_q;
  logic [7:0]  grant_time_q, resv_id_q;
  logic        resv_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q  <= '0;
      host_bits_q  <= 4'd8;
      grant_time_q <= 8'd10;
      resv_en_q    <= 1'b0;
      resv_id_q    <= '0;
      offer_opt_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_POOL_BASE:  pool_base_q  <= cfg_data_i;
        CFG_HOST_BITS:  host_bits_q  <= cfg_data_i[3:0];
        CFG_GRANT_TIME: grant_time_q <= cfg_data_i[7:0];
        CFG_RESV_EN:    resv_en_q    <= cfg_data_i[0];
        CFG_RESV_ID:    resv_id_q    <= cfg_data_i[7:0];
        CFG_OFFER_OPT:  offer_opt_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // control and working registers
  state_e          state_q, state_d;
  logic [ID_W-1:0] next_host_q, next_host_d;
  logic [ID_W-1:0] cnt_q, cnt_d;        // clear/tick index, discover probe count
  logic [ID_W-1:0] chk_q, chk_d;        // discover probe ID, request ID
  logic [ID_W-1:0] wa_q, wa_d;          // tick write-back address
  logic            in_tbl_q, in_tbl_d;
  logic [47:0]     hw_q, hw_d;
  logic [31:0]     req_q, req_d;
  logic            uc_q, uc_d;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  kind_q, kind_d;
  logic [47:0] echo_q, echo_d;
  logic [31:0] gaddr_q, gaddr_d;
  logic [31:0] oaddr_q, oaddr_d;
  logic        ucast_q, ucast_d;

  // RAM port
  logic              we, re;
  logic [ID_W-1:0]   waddr, raddr;
  logic [LIFE_W-1:0] wdata, rdata;

  dhcp_lta_ram #(
    .Width(LIFE_W),
    .Depth(POOL_DEPTH)
  ) u_life_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  logic            in_xfer, out_free;
  logic [ID_W-1:0] max_id, h0, chk_nxt;
  logic [31:0]     req_off;
  logic [7:0]      g_life;
  logic            chk_resv, chk_free, disc_last;
  logic [LIFE_W-1:0] eff_life;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign max_id  = span_max(host_bits_q);
  assign h0      = (next_host_q == '0 || next_host_q > max_id) ? ID_W'(1) : next_host_q;
  assign chk_nxt = (chk_q == max_id) ? ID_W'(1) : chk_q + ID_W'(1);
  assign req_off = requested_addr_i - pool_base_q;

  always_comb begin
    g_life = grant_time_q;
    if (g_life < LIFE_MIN) g_life = LIFE_MIN;
    if (g_life > LIFE_MAX) g_life = LIFE_MAX;
  end

  // reserved ID reads as leased forever
  assign chk_resv  = resv_en_q && (32'(resv_id_q) == 32'(chk_q));
  assign eff_life  = chk_resv ? LIFE_INF : rdata;
  assign chk_free  = (eff_life == LIFE_FREE);
  assign disc_last = (cnt_q == max_id - ID_W'(1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (cnt_q == LastId) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (cmd_e'(cmd_i))
            CMD_DISCOVER: state_d = ST_DISC;
            CMD_REQUEST:  state_d = ST_REQ;
            CMD_TICK:     state_d = ST_TICK;
            CMD_NONE:     state_d = ST_IDLE;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_DISC: begin
        if ((chk_free || disc_last) && out_free) state_d = ST_IDLE;
      end
      ST_REQ: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_TICK: begin
        if (cnt_q == LastId) state_d = ST_TICK_END;
      end
      ST_TICK_END: state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    next_host_d = next_host_q;
    cnt_d       = cnt_q;
    chk_d       = chk_q;
    wa_d        = wa_q;
    in_tbl_d    = in_tbl_q;
    hw_d        = hw_q;
    req_d       = req_q;
    uc_d        = uc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    echo_d      = echo_q;
    gaddr_d     = gaddr_q;
    oaddr_d     = oaddr_q;
    ucast_d     = ucast_q;
    we          = 1'b0;
    waddr       = cnt_q;
    wdata       = LIFE_FREE;
    re          = 1'b0;
    raddr       = cnt_q;

    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        cnt_d = cnt_q + ID_W'(1);
      end
      ST_IDLE: begin
        if (in_xfer) begin
          hw_d  = client_hw_i;
          req_d = requested_addr_i;
          uc_d  = (sender_addr_i == requested_addr_i);
          cnt_d = '0;
          if (cmd_i == CMD_DISCOVER) begin
            re    = 1'b1;
            raddr = h0;
            chk_d = h0;
          end else if (cmd_i == CMD_REQUEST) begin
            re       = 1'b1;
            raddr    = req_off[ID_W-1:0];
            chk_d    = req_off[ID_W-1:0];
            in_tbl_d = (req_off < POOL_DEPTH);
          end
        end
      end
      ST_DISC: begin
        if (out_free) begin
          if (chk_free) begin
            we          = 1'b1;
            waddr       = chk_q;
            wdata       = g_life;
            next_host_d = chk_nxt;
            out_valid_d = 1'b1;
            kind_d      = MSG_OFFER;
            echo_d      = hw_q;
            gaddr_d     = pool_base_q + 32'(chk_q);
            oaddr_d     = offer_opt_q;
            ucast_d     = 1'b0;
          end else if (disc_last) begin
            out_valid_d = 1'b1;
            kind_d      = MSG_EXHAUSTED;
            echo_d      = hw_q;
            gaddr_d     = '0;
            oaddr_d     = '0;
            ucast_d     = 1'b0;
          end else begin
            re    = 1'b1;
            raddr = chk_nxt;
            chk_d = chk_nxt;
            cnt_d = cnt_q + ID_W'(1);
          end
        end
      end
      ST_REQ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          echo_d      = hw_q;
          gaddr_d     = req_q;
          oaddr_d     = '0;
          if (in_tbl_q && !chk_free) begin
            kind_d  = MSG_ACK;
            ucast_d = uc_q;
            if (!chk_resv && rdata < LIFE_MAX) begin
              we    = 1'b1;
              waddr = chk_q;
              wdata = rdata + 8'd1;
            end
          end else begin
            kind_d  = MSG_NACK;
            ucast_d = 1'b0;
          end
        end
      end
      ST_TICK: begin
        // read entry cnt while writing back the previous one
        re    = 1'b1;
        raddr = cnt_q;
        we    = (cnt_q != '0);
        waddr = wa_q;
        wdata = tick_life(rdata);
        wa_d  = cnt_q;
        cnt_d = cnt_q + ID_W'(1);
      end
      ST_TICK_END: begin
        we    = 1'b1;
        waddr = wa_q;
        wdata = tick_life(rdata);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      next_host_q <= ID_W'(1);
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_host_q <= next_host_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_q    <= chk_d;
    wa_q     <= wa_d;
    in_tbl_q <= in_tbl_d;
    hw_q     <= hw_d;
    req_q    <= req_d;
    uc_q     <= uc_d;
    kind_q   <= kind_d;
    echo_q   <= echo_d;
    gaddr_q  <= gaddr_d;
    oaddr_q  <= oaddr_d;
    ucast_q  <= ucast_d;
  end

  assign out_valid_o    = out_valid_q;
  assign msg_kind_o     = kind_q;
  assign client_echo_o  = echo_q;
  assign granted_addr_o = gaddr_q;
  assign option_addr_o  = oaddr_q;
  assign unicast_o      = ucast_q;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the DHCP lease pool engine. Discover, request and
// tick messages go in through a ready/valid channel. A lease table kept on the
// bench side predicts every offer, ack, nack and exhaustion reply, and each
// reply is compared field by field in order. The pool registers are rewritten
// between phases while the engine is quiet.
// ----------------------------------------------------------------------------
module testbench
  import dhcp_lta_pkg::*;
();

  typedef struct {
    cmd_e        cmd;
    logic [47:0] hw;
    logic [31:0] req;
    logic [31:0] snd;
  } pool_msg_t;

  typedef struct {
    msg_kind_e   kind;
    logic [47:0] echo;
    logic [31:0] addr;
    logic [31:0] opt;
    logic        uc;
  } pool_reply_t;

  // Lease table mirror plus the queue of replies still owed by the engine.
  class lease_board;
    logic [LIFE_W-1:0] life [POOL_DEPTH];
    int                cursor;
    logic [31:0]       base;
    logic [3:0]        hbits;
    logic [7:0]        grant;
    logic              resv_en;
    logic [7:0]        resv_id;
    logic [31:0]       offer_opt;
    pool_reply_t       replies_due [$];
    bit                offer_fresh;
    logic [31:0]       last_offer;
    logic [47:0]       last_hw;
    int                errors;
    int                ticks;
    int                kind_seen [4];

    function new();
      foreach (life[i]) life[i] = LIFE_FREE;
      cursor    = 1;
      base      = '0;
      hbits     = 4'd8;
      grant     = 8'd10;
      resv_en   = 1'b0;
      resv_id   = '0;
      offer_opt = '0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [31:0] d);
      case (idx)
        CFG_POOL_BASE:  base      = d;
        CFG_HOST_BITS:  hbits     = d[3:0];
        CFG_GRANT_TIME: grant     = d[7:0];
        CFG_RESV_EN:    resv_en   = d[0];
        CFG_RESV_ID:    resv_id   = d[7:0];
        CFG_OFFER_OPT:  offer_opt = d;
        default: ;
      endcase
    endfunction

    function int span_top();
      int hb;
      hb = hbits;
      if (hb < 1) hb = 1;
      if (hb > 8) hb = 8;
      if ((1 << hb) > POOL_DEPTH) return POOL_DEPTH - 1;
      return (1 << hb) - 1;
    endfunction

    function bit held_by_server(int id);
      return resv_en && id == resv_id;
    endfunction

    function logic [LIFE_W-1:0] life_of(int id);
      if (held_by_server(id)) return LIFE_INF;
      return life[id];
    endfunction

    // Random ID that currently holds a lease, -1 if the table is empty.
    function int pick_leased();
      int start, k, id;
      start = $urandom_range(0, POOL_DEPTH - 1);
      for (k = 0; k < POOL_DEPTH; k++) begin
        id = (start + k) % POOL_DEPTH;
        if (life_of(id) != LIFE_FREE) return id;
      end
      return -1;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    function void apply_message(pool_msg_t m);
      pool_reply_t r;
      int          top, h, n, g;
      logic [31:0] offs;
      r.kind = MSG_NACK;
      r.echo = m.hw;
      r.addr = '0;
      r.opt  = '0;
      r.uc   = 1'b0;
      case (m.cmd)
        CMD_DISCOVER: begin
          top = span_top();
          h   = cursor;
          if (h == 0 || h > top) h = 1;
          g = grant;
          if (g < LIFE_MIN) g = LIFE_MIN;
          if (g > LIFE_MAX) g = LIFE_MAX;
          // next-fit probe, at most one lap of the span
          n = 0;
          while (n < top && life_of(h) != LIFE_FREE) begin
            h = h % top + 1;
            n++;
          end
          if (n < top) begin
            life[h]     = 8'(g);
            cursor      = h % top + 1;
            r.kind      = MSG_OFFER;
            r.addr      = base + 32'(h);
            r.opt       = offer_opt;
            last_offer  = r.addr;
            last_hw     = m.hw;
            offer_fresh = 1'b1;
          end else begin
            r.kind = MSG_EXHAUSTED;
          end
        end
        CMD_REQUEST: begin
          offs   = m.req - base;
          r.addr = m.req;
          if (offs < POOL_DEPTH && life_of(int'(offs)) != LIFE_FREE) begin
            if (!held_by_server(int'(offs)) && life[offs] < LIFE_MAX)
              life[offs] = life[offs] + 8'd1;
            r.kind = MSG_ACK;
            r.uc   = (m.snd == m.req);
          end
        end
        CMD_TICK: begin
          foreach (life[i]) begin
            if (life[i] <= 8'd1) life[i] = LIFE_FREE;
            else if (life[i] != LIFE_INF) life[i] = life[i] - 8'd1;
          end
          ticks++;
        end
        default: ;
      endcase
      if (m.cmd == CMD_DISCOVER || m.cmd == CMD_REQUEST) replies_due = {replies_due, r};
    endfunction

    function void check_reply(msg_kind_e kind, logic [47:0] echo, logic [31:0] addr,
                              logic [31:0] opt, logic uc);
      pool_reply_t want;
      if (replies_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: reply with nothing outstanding: kind=%0d echo=%h addr=%h",
                   $realtime, kind, echo, addr);
        return;
      end
      want = replies_due.pop_front();
      kind_seen[want.kind]++;
      if (kind !== want.kind || echo !== want.echo || addr !== want.addr ||
          opt !== want.opt || uc !== want.uc) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: reply mismatch\n  exp kind=%0d echo=%h addr=%h opt=%h uc=%b",
                   $realtime, want.kind, want.echo, want.addr, want.opt, want.uc);
          $display("  got kind=%0d echo=%h addr=%h opt=%h uc=%b",
                   kind, echo, addr, opt, uc);
        end
      end
    endfunction
  endclass

  logic                 clk_i            = 1'b0;
  logic                 rst_ni           = 1'b0;
  logic                 in_valid_i       = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           cmd_i            = '0;
  logic [47:0]          client_hw_i      = '0;
  logic [31:0]          requested_addr_i = '0;
  logic [31:0]          sender_addr_i    = '0;
  logic                 out_valid_o;
  logic                 out_ready_i      = 1'b0;
  logic [1:0]           msg_kind_o;
  logic [47:0]          client_echo_o;
  logic [31:0]          granted_addr_o;
  logic [31:0]          option_addr_o;
  logic                 unicast_o;
  logic                 cfg_valid_i      = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i      = '0;
  logic [31:0]          cfg_data_i       = '0;

  lease_board board;
  int         msgs_sent;
  int         settings_used;
  int         hold_len;
  bit         tx_steady;
  bit         rx_steady;

  always #2 clk_i = ~clk_i;

  dhcp_lease_table_allocator_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .client_hw_i      (client_hw_i),
    .requested_addr_i (requested_addr_i),
    .sender_addr_i    (sender_addr_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .msg_kind_o       (msg_kind_o),
    .client_echo_o    (client_echo_o),
    .granted_addr_o   (granted_addr_o),
    .option_addr_o    (option_addr_o),
    .unicast_o        (unicast_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i)
      board.check_reply(msg_kind_e'(msg_kind_o), client_echo_o, granted_addr_o,
                        option_addr_o, unicast_o);
  end

  // Reply side: random stalls per transfer, plus one long hold-off on request.
  initial begin : reply_sink
    int stall;
    @(negedge clk_i);
    forever begin
      if (hold_len != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_len) @(negedge clk_i);
        hold_len = 0;
      end
      if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
      stall = rx_steady ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      @(negedge clk_i);
    end
  end

  function automatic pool_msg_t mk_msg(cmd_e c, logic [47:0] hw, logic [31:0] req,
                                       logic [31:0] snd);
    pool_msg_t m;
    m.cmd = c;
    m.hw  = hw;
    m.req = req;
    m.snd = snd;
    return m;
  endfunction

  // Mostly DHCP-shaped traffic: a discover is often followed by a request for
  // the offered address; requests favor leased IDs over stray addresses.
  function automatic pool_msg_t random_msg();
    pool_msg_t m;
    int        pick, id;
    m = mk_msg(CMD_DISCOVER, {16'($urandom), $urandom}, $urandom, $urandom);
    if (board.offer_fresh && $urandom_range(0, 9) < 7) begin
      board.offer_fresh = 1'b0;
      m.cmd = CMD_REQUEST;
      m.hw  = board.last_hw;
      m.req = board.last_offer;
      m.snd = $urandom_range(0, 1) ? m.req : 32'd0;
      return m;
    end
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      m.cmd = CMD_DISCOVER;
    end else if (pick < 80) begin
      m.cmd = CMD_REQUEST;
      pick  = $urandom_range(0, 9);
      id    = board.pick_leased();
      if (pick < 6 && id >= 0) m.req = board.base + 32'(id);
      else if (pick < 8) m.req = board.base + 32'($urandom_range(0, POOL_DEPTH - 1));
      else if (pick == 9) begin
        if ($urandom_range(0, 1)) m.req = board.base + 32'(POOL_DEPTH + $urandom_range(0, 999));
        else m.req = board.base - 32'($urandom_range(1, 999));
      end
      if ($urandom_range(0, 1)) m.snd = m.req;
    end else if (pick < 95) begin
      m.cmd = CMD_TICK;
    end else begin
      m.cmd = CMD_NONE;
    end
    return m;
  endfunction

  task automatic push_msg(input pool_msg_t m);
    int gap;
    if ($urandom_range(0, 15) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    cmd_i            <= m.cmd;
    client_hw_i      <= m.hw;
    requested_addr_i <= m.req;
    sender_addr_i    <= m.snd;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    board.apply_message(m);
    msgs_sent++;
    @(negedge clk_i);
  endtask

  task automatic run_random(int count);
    pool_msg_t m;
    int        done;
    done = 0;
    while (done < count) begin
      m = random_msg();
      push_msg(m);
      if (m.cmd != CMD_NONE) done++;
    end
  endtask

  // Wait out every owed reply, then a full tick sweep, since a tick has no reply.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (POOL_DEPTH + 16) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    board.set_reg(idx, d);
    @(negedge clk_i);
  endtask

  task automatic set_pool(logic [31:0] base_v, logic [3:0] hb, logic [7:0] gt,
                          logic en, logic [7:0] rid, logic [31:0] opt);
    drain();
    write_reg(CFG_POOL_BASE, base_v);
    write_reg(CFG_HOST_BITS, 32'(hb));
    write_reg(CFG_GRANT_TIME, 32'(gt));
    write_reg(CFG_RESV_EN, 32'(en));
    write_reg(CFG_RESV_ID, 32'(rid));
    write_reg(CFG_OFFER_OPT, opt);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  initial begin : timeout
    #6_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    board = new();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: first grants, acks both ways, nacks for free and
    // out-of-table addresses, an unknown command and a tick.
    push_msg(mk_msg(CMD_DISCOVER, 48'h0, 32'h0, 32'h0));
    push_msg(mk_msg(CMD_DISCOVER, '1, '1, '1));
    push_msg(mk_msg(CMD_REQUEST, 48'h0000_1111_2222, 32'd1, 32'd1));
    push_msg(mk_msg(CMD_REQUEST, 48'hA5A5_0000_5A5A, 32'd2, 32'd0));
    push_msg(mk_msg(CMD_REQUEST, 48'h1, 32'd7, 32'd7));
    push_msg(mk_msg(CMD_REQUEST, 48'h2, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    push_msg(mk_msg(CMD_REQUEST, 48'h3, 32'd256, 32'd0));
    push_msg(mk_msg(CMD_NONE, {16'($urandom), $urandom}, $urandom, $urandom));
    push_msg(mk_msg(CMD_TICK, 48'h0, 32'h0, 32'h0));

    // Tiny span with the server's address held and the base wrapping past 2^32;
    // grant time below range. Fill, expire and regrant.
    set_pool(32'hFFFF_FFFE, 4'd2, 8'd0, 1'b1, 8'd2, 32'hFFFF_FFFF);
    push_msg(mk_msg(CMD_DISCOVER, 48'h10, 32'h0, 32'h0));
    push_msg(mk_msg(CMD_DISCOVER, 48'h11, 32'h0, 32'h0));
    push_msg(mk_msg(CMD_REQUEST, 48'h12, 32'h0, 32'h0));
    push_msg(mk_msg(CMD_REQUEST, 48'h13, 32'd198, 32'd198));
    push_msg(mk_msg(CMD_REQUEST, 48'h14, 32'hFFFF_FFFF, 32'h0));
    push_msg(mk_msg(CMD_TICK, 48'h0, 32'h0, 32'h0));
    push_msg(mk_msg(CMD_TICK, 48'h0, 32'h0, 32'h0));
    push_msg(mk_msg(CMD_DISCOVER, 48'h15, 32'h0, 32'h0));

    // Host bits and grant time above range; the raise saturates at the top.
    set_pool(32'h0, 4'd15, 8'd255, 1'b0, 8'd255, 32'h0);
    push_msg(mk_msg(CMD_DISCOVER, 48'h20, 32'h0, 32'h0));
    push_msg(mk_msg(CMD_REQUEST, 48'h21, 32'd4, 32'd4));
    push_msg(mk_msg(CMD_REQUEST, 48'h22, 32'd2, 32'd9));
    push_msg(mk_msg(CMD_TICK, 48'h0, 32'h0, 32'h0));

    set_pool(32'h0A00_0000, 4'd8, 8'd10, 1'b0, 8'd0, $urandom);
    run_random(160);
    set_pool(32'hC0A8_0100, 4'd3, 8'd4, 1'b1, 8'd5, $urandom);
    run_random(160);
    // single-address span; the old pointer falls outside it
    set_pool(32'hFFFF_FF80, 4'd0, 8'd1, 1'b1, 8'd0, 32'hFFFF_FFFF);
    run_random(100);
    set_pool($urandom, 4'd15, 8'd254, 1'b1, 8'd255, $urandom);
    run_random(160);
    set_pool(32'hFFFF_FFFF, 4'd2, 8'd2, 1'b0, 8'd3, 32'h0);
    run_random(140);
    set_pool($urandom, 4'd5, 8'($urandom_range(2, 254)), 1'b1,
             8'($urandom_range(0, 255)), $urandom);
    @(negedge clk_i);
    write_reg(CFG_UNUSED7, $urandom);
    cfg_valid_i <= 1'b0;
    // long output stall so the engine backs up into its input
    hold_len = 400;
    run_random(180);

    drain();
    $display("lease pool run: %0d messages incl. %0d ticks, %0d register settings",
             msgs_sent, board.ticks, settings_used + 1);
    $display("replies: %0d offers, %0d acks, %0d nacks, %0d exhausted, %0d mismatches",
             board.kind_seen[MSG_OFFER], board.kind_seen[MSG_ACK],
             board.kind_seen[MSG_NACK], board.kind_seen[MSG_EXHAUSTED], board.errors);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/dhcp_lta_pkg.sv
rtl/core/dhcp_lta_ram.sv
rtl/core/dhcp_lease_table_allocator_top.sv
verif/testbench.sv
